>>> rtl/core/euclidean_distance_stream_core_assert.svh
// Assertion macros for the Euclidean distance stream core.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef EUCLIDEAN_DISTANCE_STREAM_CORE_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define EDS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define EDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

>>> rtl/core/eds_pkg.sv
// Shared types and constants for the Euclidean distance stream core.
// No dependencies.
package eds_pkg;

	localparam int ELEM_BITS        = 16;
	localparam int DIST_BITS        = 32;
	localparam int SUM_BITS_DEF     = 48;
	localparam int FRAC_BITS_DEF    = 8;
	localparam int QUEUE_DEPTH      = 2;

	typedef struct packed {
		logic signed [ELEM_BITS-1:0] elem_a;
		logic signed [ELEM_BITS-1:0] elem_b;
		logic                        last;
	} pair_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic                 saturated;
	} result_t;

endpackage

>>> rtl/core/eds_front.sv
// Front end: takes element pairs, squares their difference and keeps the running sum.
// Depends on eds_pkg; hands finished sums to the job queue.
module eds_front import eds_pkg::*; #(
	parameter int SUM_BITS = SUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	output logic                pair_stall,
	input  pair_t               pair,
	input  logic                q_full,
	output logic                q_push,
	output logic [SUM_BITS:0]   q_wdata
);

	localparam int MAG_BITS = ELEM_BITS + 1;
	localparam int SQ_BITS  = 2 * MAG_BITS;
	localparam int ADD_W    = ((SUM_BITS > SQ_BITS) ? SUM_BITS : SQ_BITS) + 1;

	logic                       advance;
	logic                       acc_in;
	logic signed [MAG_BITS-1:0] diff;
	logic        [MAG_BITS-1:0] mag;
	logic                       v_s1;
	logic                       last_s1;
	logic        [MAG_BITS-1:0] mag_s1;
	logic                       v_s2;
	logic                       last_s2;
	logic        [SQ_BITS-1:0]  sq_s2;
	logic        [SUM_BITS-1:0] sum_q;
	logic                       ovf_q;
	logic        [ADD_W-1:0]    sum_ext;
	logic                       ovf_add;
	logic        [SUM_BITS-1:0] sum_new;
	logic                       ovf_new;

	// The whole pipeline holds only when a finished sum cannot enter the queue.
	assign advance    = !(v_s2 && last_s2 && q_full);
	assign pair_stall = !advance;
	assign acc_in     = pair_valid && advance;

	assign diff = MAG_BITS'(pair.elem_a) - MAG_BITS'(pair.elem_b);
	assign mag  = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);

	assign sum_ext = ADD_W'(sum_q) + ADD_W'(sq_s2);
	assign ovf_add = |sum_ext[ADD_W-1:SUM_BITS];
	assign sum_new = ovf_add ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
	assign ovf_new = ovf_q | ovf_add;

	assign q_push  = advance && v_s2 && last_s2;
	assign q_wdata = {ovf_new, sum_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= acc_in;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (last_s2) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_new;
					ovf_q <= ovf_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mag_s1  <= mag;
			last_s1 <= pair.last;
			sq_s2   <= mag_s1 * mag_s1;
			last_s2 <= last_s1;
		end
	end

endmodule

>>> rtl/core/eds_queue.sv
// Small first-in first-out queue between the accumulator and the root unit.
// Depends on eds_pkg for its depth.
module eds_queue import eds_pkg::*; #(
	parameter int WIDTH = SUM_BITS_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= wdata;
		end
	end

endmodule

>>> rtl/core/eds_root.sv
// Back end: bit-serial fixed-point square root of one queued sum, plus the result register.
// Depends on eds_pkg for the result type.
module eds_root import eds_pkg::*; #(
	parameter int SUM_BITS  = SUM_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_empty,
	input  logic [SUM_BITS:0] job_data,
	output logic              job_pop,
	output logic              dist_valid,
	input  logic              dist_stall,
	output result_t           result
);

	localparam int NW    = SUM_BITS + 2 * FRAC_BITS;
	localparam int RW    = (NW + 1) / 2;
	localparam int NPW   = 2 * RW;
	localparam int REM_W = RW + 3;
	localparam int CNT_W = $clog2(RW);
	localparam int RWE   = (RW > DIST_BITS) ? RW : DIST_BITS + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NPW-1:0]   n_q;
	logic [REM_W-1:0] rem_q;
	logic [RW-1:0]    root_q;
	logic             sat_q;
	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             take;
	logic [RWE-1:0]   root_ext;
	logic             too_wide;
	logic             load_out;
	result_t          res_q;
	logic             res_valid_q;

	// One result bit per cycle: bring down two bits of the radicand and try a one.
	assign rem_sh = {rem_q[REM_W-3:0], n_q[NPW-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign take   = (rem_sh >= trial);

	assign root_ext = RWE'(root_q);
	assign too_wide = |root_ext[RWE-1:DIST_BITS];

	assign job_pop  = (state_q == S_IDLE) && !job_empty;
	assign load_out = (state_q == S_DONE) && (!res_valid_q || !dist_stall);

	assign dist_valid = res_valid_q;
	assign result     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!job_empty) begin
						state_q <= S_RUN;
						cnt_q   <= '0;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(RW - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (!dist_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			n_q    <= NPW'(job_data[SUM_BITS-1:0]) << (2 * FRAC_BITS);
			rem_q  <= '0;
			root_q <= '0;
			sat_q  <= job_data[SUM_BITS];
		end else if (state_q == S_RUN) begin
			n_q    <= n_q << 2;
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RW-2:0], take};
		end
		if (load_out) begin
			res_q.distance  <= too_wide ? {DIST_BITS{1'b1}} : root_ext[DIST_BITS-1:0];
			res_q.saturated <= sat_q;
		end
	end

endmodule

>>> rtl/core/euclidean_distance_stream_core.sv
// Euclidean distance stream core: top level; uses eds_pkg, eds_front, eds_queue, eds_root.
// Throughput: one element pair per cycle while the root unit keeps up with the vectors.
// Root: one bit per cycle, (SUM_BITS + 2*FRAC_BITS + 1)/2 result bits (32 at defaults).
// Short vectors back up in a two-entry queue; when it is full and a finished sum waits, pair_stall rises.
// Reset clears the sum, the flag, the pipeline, the queue and the root state; no clearing pass.
`include "euclidean_distance_stream_core_assert.svh"

module euclidean_distance_stream_core import eds_pkg::*; #(
	parameter int SUM_BITS  = SUM_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pair_valid,
	output logic    pair_stall,
	input  pair_t   pair,
	output logic    dist_valid,
	input  logic    dist_stall,
	output result_t result
);

	// Signals between the front end, the job queue and the root unit. A job is the
	// finished sum of squares of one vector with its saturation flag on top.
	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_empty;
	logic [SUM_BITS:0] q_wdata;
	logic [SUM_BITS:0] q_rdata;

	// The front end squares each difference and adds it into a saturating sum. It
	// runs freely and holds only when a last beat finds the queue full.
	eds_front #(
		.SUM_BITS(SUM_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	// The queue lets the accumulator start on the next vector while a root is
	// still being worked out.
	eds_queue #(
		.WIDTH(SUM_BITS + 1)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The root unit takes one job at a time and presents its result in an output
	// register; while a result is stalled it takes no new job, so the queue may fill.
	eds_root #(
		.SUM_BITS  (SUM_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_root (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_empty  (q_empty),
		.job_data   (q_rdata),
		.job_pop    (q_pop),
		.dist_valid (dist_valid),
		.dist_stall (dist_stall),
		.result     (result)
	);

	// The front end only holds back when a finished sum is waiting on a full queue.
	`EDS_ASSERT_IMP(a_stall_only_when_full, pair_stall, q_full)
	// No job is ever pushed into a full queue or popped from an empty one.
	`EDS_ASSERT_IMP(a_no_push_when_full, q_push, !q_full)
	`EDS_ASSERT_IMP(a_no_pop_when_empty, q_pop, !q_empty)
	// A push without a pop leaves the queue holding at least one job.
	`EDS_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_empty)

endmodule
